@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL.
// Clock is clk, reset is rst_n (active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/dsr_pkg.sv @@
// Disk request scheduler package: policy codes, control structs, output layout.
// No dependencies.
`timescale 1ns / 1ps

package dsr_pkg;

  localparam int TOTAL_BITS  = 20;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = 20'hFFFFF;
  localparam int FIELD_BITS  = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * FIELD_BITS - TOTAL_BITS;

  typedef enum logic [1:0] {
    POL_FCFS  = 2'd0,
    POL_SSTF  = 2'd1,
    POL_CLOOK = 2'd2,
    POL_LOOK  = 2'd3
  } policy_t;

  typedef struct packed {
    logic head_we;
    logic req_we;
    logic batch_start;
    logic rd_en;
    logic rd_first;
    logic swap_a;
    logic swap_b;
    logic emit;
    logic last;
  } dsr_cmd_t;

  typedef struct packed {
    logic slot_free;
  } dsr_stat_t;

endpackage

@@ hw/rtl/dsr_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module dsr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

@@ hw/rtl/dsr_dp.sv @@
// Scheduler datapath: request RAM, scan compare stage, candidates, output register.
// Depends on dsr_pkg and dsr_ram.
`timescale 1ns / 1ps

module dsr_dp import dsr_pkg::*; #(
  parameter int NUM_REQ    = 8,
  parameter int TRACK_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [IN_TDATA_W-1:0]      in_tdata,
  input  dsr_cmd_t                   cmd,
  input  policy_t                    policy,
  input  logic [$clog2(NUM_REQ)-1:0] ld_idx,
  input  logic [$clog2(NUM_REQ)-1:0] rd_idx,
  input  logic [$clog2(NUM_REQ)-1:0] out_idx,
  output dsr_stat_t                  stat,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [OUT_TDATA_W-1:0]     out_tdata,
  output logic                       out_tlast
);

  localparam int IW = $clog2(NUM_REQ);
  localparam int TW = TRACK_BITS;
  localparam int SW = (TW > TOTAL_BITS) ? TW + 1 : TOTAL_BITS + 1;

  logic [TW-1:0]         track_in;
  logic [TW-1:0]         head_r, cur_r;
  logic [TOTAL_BITS-1:0] total_r, total_nxt;
  logic [NUM_REQ-1:0]    served_r;
  logic                  cmp_vld_r, cmp_first_r;
  logic [IW-1:0]         cmp_idx_r;
  logic                  a_found_r, b_found_r;
  logic [TW-1:0]         a_val_r, a_gap_r, b_val_r, first_val_r;
  logic [IW-1:0]         a_idx_r, b_idx_r;
  logic                  out_valid_r, out_last_r;
  logic [FIELD_BITS-1:0] out_trk_r, out_dist_r;
  logic [TOTAL_BITS-1:0] out_total_r;

  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [TW-1:0]         ram_wdata, rdata;
  logic [TW-1:0]         gap_rd, pick_val, step_gap;
  logic [IW-1:0]         pick_idx;
  logic                  look, served_rd;
  logic                  elig_a, elig_b, better_a, better_b, take_a, take_b;
  logic [SW-1:0]         sum;

  assign track_in = TW'(in_tdata);
  assign pick_val = a_found_r ? a_val_r : b_val_r;
  assign pick_idx = a_found_r ? a_idx_r : b_idx_r;

  always_comb begin
    ram_we    = cmd.req_we || cmd.swap_a || cmd.swap_b;
    ram_waddr = ld_idx;
    ram_wdata = track_in;
    if (cmd.swap_a) begin
      ram_waddr = out_idx;
      ram_wdata = pick_val;
    end else if (cmd.swap_b) begin
      ram_waddr = pick_idx;
      ram_wdata = first_val_r;
    end
  end

  dsr_ram #(.WIDTH(TW), .DEPTH(NUM_REQ)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  // compare stage on the entry read last cycle
  always_comb begin
    gap_rd    = (rdata >= cur_r) ? rdata - cur_r : cur_r - rdata;
    look      = (policy == POL_CLOOK) || (policy == POL_LOOK);
    served_rd = served_r[cmp_idx_r];
    elig_a    = !look || (!served_rd && rdata >= head_r);
    elig_b    = look && !served_rd && rdata < head_r;
    case (policy)
      POL_SSTF:  better_a = gap_rd < a_gap_r;
      POL_CLOOK: better_a = rdata < a_val_r;
      POL_LOOK:  better_a = rdata < a_val_r;
      default:   better_a = 1'b0;
    endcase
    better_b = (policy == POL_LOOK) ? rdata > b_val_r : rdata < b_val_r;
    take_a   = cmp_vld_r && elig_a && (cmp_first_r || !a_found_r || better_a);
    take_b   = cmp_vld_r && elig_b && (cmp_first_r || !b_found_r || better_b);
  end

  always_comb begin
    step_gap  = (pick_val >= cur_r) ? pick_val - cur_r : cur_r - pick_val;
    sum       = SW'(total_r) + SW'(step_gap);
    total_nxt = (sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
  end

  assign stat.slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      served_r    <= '0;
      cmp_vld_r   <= 1'b0;
      a_found_r   <= 1'b0;
      b_found_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.rd_en;
      if (cmp_vld_r) begin
        a_found_r <= (a_found_r && !cmp_first_r) || elig_a;
        b_found_r <= (b_found_r && !cmp_first_r) || elig_b;
      end
      if (cmd.batch_start) begin
        served_r <= '0;
      end else if (cmd.emit) begin
        served_r[pick_idx] <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_first_r <= cmd.rd_first;
    cmp_idx_r   <= rd_idx;
    if (cmd.head_we) begin
      head_r <= track_in;
    end
    if (cmd.batch_start) begin
      cur_r   <= head_r;
      total_r <= '0;
    end else if (cmd.emit) begin
      cur_r   <= pick_val;
      total_r <= total_nxt;
    end
    if (cmp_vld_r && cmp_first_r) begin
      first_val_r <= rdata;
    end
    if (take_a) begin
      a_val_r <= rdata;
      a_gap_r <= gap_rd;
      a_idx_r <= cmp_idx_r;
    end
    if (take_b) begin
      b_val_r <= rdata;
      b_idx_r <= cmp_idx_r;
    end
    if (cmd.emit) begin
      out_trk_r   <= FIELD_BITS'(pick_val);
      out_dist_r  <= FIELD_BITS'(step_gap);
      out_total_r <= total_nxt;
      out_last_r  <= cmd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_total_r, out_dist_r, out_trk_r};

endmodule

@@ hw/rtl/dsr_ctrl.sv @@
// Scheduler controller: load counter, scan sequencing, swap and emit steps.
// Depends on dsr_pkg.
`timescale 1ns / 1ps

module dsr_ctrl import dsr_pkg::*; #(
  parameter int NUM_REQ = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_wdata,
  input  dsr_stat_t                  stat,
  output dsr_cmd_t                   cmd,
  output policy_t                    policy,
  output logic [$clog2(NUM_REQ)-1:0] ld_idx,
  output logic [$clog2(NUM_REQ)-1:0] rd_idx,
  output logic [$clog2(NUM_REQ)-1:0] out_idx
);

  localparam int IW = $clog2(NUM_REQ);
  localparam int CW = $clog2(NUM_REQ + 1);
  localparam logic [CW-1:0] LOAD_LAST = CW'(NUM_REQ);
  localparam logic [IW-1:0] IDX_LAST  = IW'(NUM_REQ - 1);

  typedef enum logic [2:0] {
    ST_LOAD, ST_SCAN, ST_DRAIN, ST_SWAP_A, ST_SWAP_B, ST_EMIT
  } state_t;

  state_t        state_r;
  logic [CW-1:0] cnt_r;
  logic [IW-1:0] rd_idx_r, out_idx_r;
  logic          first_r;
  policy_t       mode_r;
  logic          in_accept, look;
  logic [IW-1:0] scan_end;

  assign in_tready = (state_r == ST_LOAD);
  assign in_accept = in_tvalid && in_tready;
  assign look      = (mode_r == POL_CLOOK) || (mode_r == POL_LOOK);
  assign scan_end  = (mode_r == POL_FCFS) ? out_idx_r : IDX_LAST;
  assign ld_idx    = IW'(cnt_r - CW'(1));
  assign rd_idx    = rd_idx_r;
  assign out_idx   = out_idx_r;
  assign policy    = mode_r;

  always_comb begin
    cmd             = '0;
    cmd.head_we     = in_accept && (cnt_r == '0);
    cmd.req_we      = in_accept && (cnt_r != '0);
    cmd.batch_start = in_accept && (cnt_r == LOAD_LAST);
    cmd.rd_en       = (state_r == ST_SCAN);
    cmd.rd_first    = first_r;
    cmd.swap_a      = (state_r == ST_SWAP_A);
    cmd.swap_b      = (state_r == ST_SWAP_B);
    cmd.emit        = (state_r == ST_EMIT) && stat.slot_free;
    cmd.last        = (out_idx_r == IDX_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      cnt_r     <= '0;
      rd_idx_r  <= '0;
      out_idx_r <= '0;
      first_r   <= 1'b0;
      mode_r    <= POL_FCFS;
    end else begin
      if (cfg_we) begin
        mode_r <= policy_t'(cfg_wdata);
      end
      case (state_r)
        ST_LOAD: begin
          if (in_accept) begin
            if (cnt_r == LOAD_LAST) begin
              cnt_r     <= '0;
              out_idx_r <= '0;
              rd_idx_r  <= '0;
              first_r   <= 1'b1;
              state_r   <= ST_SCAN;
            end else begin
              cnt_r <= cnt_r + CW'(1);
            end
          end
        end
        ST_SCAN: begin
          first_r <= 1'b0;
          if (rd_idx_r == scan_end) begin
            state_r <= ST_DRAIN;
          end else begin
            rd_idx_r <= rd_idx_r + IW'(1);
          end
        end
        ST_DRAIN: begin
          state_r <= (mode_r == POL_SSTF) ? ST_SWAP_A : ST_EMIT;
        end
        ST_SWAP_A: begin
          state_r <= ST_SWAP_B;
        end
        ST_SWAP_B: begin
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (stat.slot_free) begin
            if (out_idx_r == IDX_LAST) begin
              state_r <= ST_LOAD;
            end else begin
              out_idx_r <= out_idx_r + IW'(1);
              rd_idx_r  <= look ? '0 : out_idx_r + IW'(1);
              first_r   <= 1'b1;
              state_r   <= ST_SCAN;
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/disk_request_scheduler.sv @@
// Channel  Dir  Beat contents
// in_      in   tdata[15:0] track (head first, then NUM_REQ requests)
// out_     out  tdata served_track, seek_distance, running_total; tlast = last
// cfg_     in   wdata[1:0] policy_mode
//
// Input is ready throughout loading. Each result then costs one RAM scan,
// one entry read per cycle from the request RAM: fcfs reads its own slot,
// sstf reads from its slot to the end and swaps the pick in, look modes
// read every entry. Reset is synchronous, active low. A held output beat
// stalls the next result; the input reopens once the last result is registered.
// Depends on dsr_pkg, dsr_ctrl, dsr_dp, dsr_ram, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module disk_request_scheduler import dsr_pkg::*; #(
  parameter int NUM_REQ    = 8,
  parameter int TRACK_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] track
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [15:0] served_track, [31:16] seek_distance,
                                             // [51:32] running_total
  output logic                   out_tlast,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_wdata
);

  localparam int IW = $clog2(NUM_REQ);

  dsr_cmd_t      cmd;
  dsr_stat_t     stat;
  policy_t       policy;
  logic [IW-1:0] ld_idx, rd_idx, out_idx;

  dsr_ctrl #(.NUM_REQ(NUM_REQ)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .cmd       (cmd),
    .policy    (policy),
    .ld_idx    (ld_idx),
    .rd_idx    (rd_idx),
    .out_idx   (out_idx)
  );

  dsr_dp #(.NUM_REQ(NUM_REQ), .TRACK_BITS(TRACK_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .policy     (policy),
    .ld_idx     (ld_idx),
    .rd_idx     (rd_idx),
    .out_idx    (out_idx),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `ASSERT_CLK(a_emit_slot, cmd.emit |-> stat.slot_free, "result written over a pending beat")
  `ASSERT_CLK(a_last_reopens, cmd.emit && cmd.last |=> in_tready, "input not reopened after batch")
  `ASSERT_CLK(a_one_op, $onehot0({cmd.req_we, cmd.rd_en, cmd.swap_a, cmd.swap_b, cmd.emit}), "overlapping datapath commands")
  `ASSERT_ALWAYS(a_no_scan_load, in_tready |-> !cmd.rd_en, "scan while loading")

endmodule

@@ bench/tb_top.sv @@
// Testbench for disk_request_scheduler: loads head/request batches under all four
// policies and checks every result beat against an in-bench scheduler predictor.
// Depends on dsr_pkg and the disk_request_scheduler RTL.
`timescale 1ns / 1ps

module tb_top import dsr_pkg::*; ();

  localparam int NREQ = 8;
  localparam int WDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [15:0] trk;
    logic [15:0] seek;
    logic [19:0] total;
    logic        last;
  } sched_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = '0;

  disk_request_scheduler u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  logic [15:0] track_q[$];
  sched_res_t  order_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_off = 0;
  bit hold_go = 0;
  bit hold_armed = 0;
  bit in_taken = 0;

  policy_t     pol = POL_FCFS;
  logic [15:0] head_pos;
  logic [15:0] req_store[NREQ];
  int          load_cnt = 0;

  function automatic logic [15:0] seek_gap(logic [15:0] a, logic [15:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  task automatic schedule_track(logic [15:0] t);
    logic [15:0] ord[NREQ];
    logic [15:0] work[NREQ+1];
    logic [15:0] tmp, cur, d, bd;
    bit          done[NREQ];
    int          best;
    logic [20:0] sum;
    sched_res_t  r;
    if (load_cnt == 0) begin
      head_pos = t;
      load_cnt = 1;
      return;
    end
    req_store[load_cnt-1] = t;
    load_cnt++;
    if (load_cnt <= NREQ) return;
    load_cnt = 0;
    case (pol)
      POL_FCFS: begin
        for (int i = 0; i < NREQ; i++) ord[i] = req_store[i];
      end
      POL_SSTF: begin
        work[0] = head_pos;
        for (int i = 0; i < NREQ; i++) work[i+1] = req_store[i];
        for (int i = 0; i < NREQ; i++) begin
          best = i + 1;
          bd = seek_gap(work[i], work[i+1]);
          for (int j = i + 2; j <= NREQ; j++) begin
            d = seek_gap(work[i], work[j]);
            if (d < bd) begin
              bd = d;
              best = j;
            end
          end
          tmp = work[i+1];
          work[i+1] = work[best];
          work[best] = tmp;
          ord[i] = work[i+1];
        end
      end
      default: begin
        for (int i = 0; i < NREQ; i++) done[i] = 0;
        for (int k = 0; k < NREQ; k++) begin
          best = -1;
          for (int i = 0; i < NREQ; i++)
            if (!done[i] && req_store[i] >= head_pos)
              if (best < 0 || req_store[i] < req_store[best]) best = i;
          if (best < 0)
            for (int i = 0; i < NREQ; i++) begin
              if (done[i]) continue;
              if (best < 0) best = i;
              else if (pol == POL_LOOK ? req_store[i] > req_store[best]
                                       : req_store[i] < req_store[best]) best = i;
            end
          done[best] = 1;
          ord[k] = req_store[best];
        end
      end
    endcase
    cur = head_pos;
    sum = '0;
    for (int i = 0; i < NREQ; i++) begin
      d = seek_gap(ord[i], cur);
      sum = sum + 21'(d);
      if (sum > 21'(TOTAL_MAX)) sum = 21'(TOTAL_MAX);
      cur = ord[i];
      r.trk = ord[i];
      r.seek = d;
      r.total = sum[19:0];
      r.last = (i == NREQ - 1);
      order_q.push_back(r);
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(0, 2);
  endfunction

  // driver
  int in_gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
    end else if (in_tvalid && !in_taken) begin
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_tvalid <= 1'b0;
    end else if (track_q.size() > 0) begin
      in_tvalid <= 1'b1;
      in_tdata <= track_q.pop_front();
      if ($urandom_range(0, 3) == 0) in_gap <= gap_len();
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) schedule_track(in_tdata);
  end

  // monitor
  sched_res_t got, want;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.trk = out_tdata[15:0];
      got.seek = out_tdata[31:16];
      got.total = out_tdata[51:32];
      got.last = out_tlast;
      if (order_q.size() == 0) begin
        report_mismatch("unexpected beat, track", got.trk, -1);
      end else begin
        want = order_q.pop_front();
        if (got.trk !== want.trk) report_mismatch("served_track", got.trk, want.trk);
        if (got.seek !== want.seek) report_mismatch("seek_distance", got.seek, want.seek);
        if (got.total !== want.total) report_mismatch("running_total", got.total, want.total);
        if (got.last !== want.last) report_mismatch("last", got.last, want.last);
      end
    end
  end

  // receiver with random stalls and one long hold-off
  int out_gap = 0;
  always @(negedge clk) begin
    if (hold_go && !hold_armed) begin
      hold_armed <= 1'b1;
      hold_off <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_gap <= gap_len();
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [15:0] rand_track();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'(16'h8000 + $urandom_range(0, 7));
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic queue_batch(logic [15:0] head, bit near);
    track_q.push_back(head);
    for (int i = 0; i < NREQ; i++)
      track_q.push_back(near ? 16'(head + $urandom_range(0, 6) - 3) : rand_track());
  endtask

  task automatic drain();
    while (track_q.size() > 0 || in_tvalid || order_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_policy(policy_t p);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= p;
    @(negedge clk);
    cfg_we <= 1'b0;
    pol = p;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed: extremes, ties, every policy
    for (int p = 0; p < 4; p++) begin
      set_policy(policy_t'(p));
      track_q.push_back(16'h8000);
      for (int i = 0; i < NREQ; i++)
        track_q.push_back(i[0] ? 16'hFFFF : 16'h0000);
      track_q.push_back(16'd100);
      for (int i = 0; i < NREQ; i++)
        track_q.push_back(i[0] ? 16'(100 + i) : 16'(100 - i));
      drain();
    end
    // random phases; long receiver hold-off during the first
    for (int ph = 0; ph < 8; ph++) begin
      set_policy(policy_t'(ph % 4));
      if (ph == 0) hold_go = 1;
      for (int b = 0; b < 3; b++) queue_batch(rand_track(), $urandom_range(0, 3) == 0);
      drain();
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/dsr_pkg.sv
hw/rtl/dsr_ram.sv
hw/rtl/dsr_dp.sv
hw/rtl/dsr_ctrl.sv
hw/rtl/disk_request_scheduler.sv
bench/tb_top.sv
